// ===== rtl/xtea_pkg.sv =====
`timescale 1ns / 1ps

package xtea_pkg;

    localparam logic [31:0] DELTA      = 32'h9E37_79B9;
    localparam int          MAX_ROUNDS = 127;
    localparam int          STAGES     = 2 * MAX_ROUNDS;
    localparam int          RC_W       = 7;
    localparam int          ADDR_W     = 3;
    localparam int          DATA_W     = 32;

    localparam logic [RC_W-1:0]   RC_RESET   = 7'd32;
    localparam logic [DATA_W-1:0] SUM_RESET  = 32'(DELTA * 32'd32);

    localparam logic [ADDR_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ROUNDS = 3'd4;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    function automatic logic [31:0] mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic logic [31:0] key_pick(input logic [127:0] key, input logic [1:0] sel);
        logic [31:0] k;
        case (sel)
            2'd0:    k = key[31:0];
            2'd1:    k = key[63:32];
            2'd2:    k = key[95:64];
            default: k = key[127:96];
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/xtea_block_cipher.sv =====
`timescale 1ns / 1ps

// An accepted input beat passes through every register stage to its result beat, for any round count;
// one register stage per half round, 127 rounds deep, idle stages pass the block through.
// Throughput: one block per cycle; a stall on the result side freezes the whole pipeline.
// Reset (synchronous, aresetn low): pipeline valid bits clear, key words clear to zero,
// round count returns to 32.
module xtea_block_cipher (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [xtea_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [xtea_pkg::DATA_W-1:0]          cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [63:0]                          s_tdata,  // block_high[31:0], block_low[63:32]
    input  logic                                 s_tuser,  // func (0 encrypt, 1 decrypt)
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [63:0]                          m_tdata   // result_high[31:0], result_low[63:32]
);
    import xtea_pkg::*;

    logic [127:0]      key_reg;
    logic [RC_W-1:0]   round_count_reg;
    logic [31:0]       dec_sum_reg;

    logic              vld_reg  [STAGES];
    logic              func_reg [STAGES];
    logic [31:0]       v0_reg   [STAGES];
    logic [31:0]       v1_reg   [STAGES];
    logic [31:0]       sum_reg  [STAGES];

    logic              vld_next  [STAGES];
    logic              func_next [STAGES];
    logic [31:0]       v0_next   [STAGES];
    logic [31:0]       v1_next   [STAGES];
    logic [31:0]       sum_next  [STAGES];

    logic              advance;

    assign advance  = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {v1_reg[STAGES-1], v0_reg[STAGES-1]};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg         <= '0;
            round_count_reg <= RC_RESET;
            dec_sum_reg     <= SUM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KEY0:   key_reg[31:0]   <= cfg_wr_data;
                REG_KEY1:   key_reg[63:32]  <= cfg_wr_data;
                REG_KEY2:   key_reg[95:64]  <= cfg_wr_data;
                REG_KEY3:   key_reg[127:96] <= cfg_wr_data;
                REG_ROUNDS: begin
                    round_count_reg <= cfg_wr_data[RC_W-1:0];
                    dec_sum_reg     <= 32'(DELTA * {25'd0, cfg_wr_data[RC_W-1:0]});
                end
                default: ;
            endcase
        end
    end

    // one half round per stage
    always_comb begin
        logic        in_func;
        logic [31:0] in_v0;
        logic [31:0] in_v1;
        logic [31:0] in_sum;
        logic        active;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                vld_next[s] = s_tvalid;
                in_func     = s_tuser;
                in_v0       = s_tdata[31:0];
                in_v1       = s_tdata[63:32];
                in_sum      = (s_tuser == FUNC_DEC) ? dec_sum_reg : 32'd0;
            end else begin
                vld_next[s] = vld_reg[s-1];
                in_func     = func_reg[s-1];
                in_v0       = v0_reg[s-1];
                in_v1       = v1_reg[s-1];
                in_sum      = sum_reg[s-1];
            end
            active       = RC_W'(s >> 1) < round_count_reg;
            func_next[s] = in_func;
            v0_next[s]   = in_v0;
            v1_next[s]   = in_v1;
            sum_next[s]  = in_sum;
            if (active) begin
                if (in_func == FUNC_ENC) begin
                    if ((s % 2) == 0) begin
                        v0_next[s]  = in_v0 + (mix(in_v1) ^
                                      (in_sum + key_pick(key_reg, in_sum[1:0])));
                        sum_next[s] = in_sum + DELTA;
                    end else begin
                        v1_next[s]  = in_v1 + (mix(in_v0) ^
                                      (in_sum + key_pick(key_reg, in_sum[12:11])));
                    end
                end else begin
                    if ((s % 2) == 0) begin
                        v1_next[s]  = in_v1 - (mix(in_v0) ^
                                      (in_sum + key_pick(key_reg, in_sum[12:11])));
                        sum_next[s] = in_sum - DELTA;
                    end else begin
                        v0_next[s]  = in_v0 - (mix(in_v1) ^
                                      (in_sum + key_pick(key_reg, in_sum[1:0])));
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < STAGES; s++) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (advance) begin
                vld_reg[s] <= vld_next[s];
            end
            if (advance) begin
                func_reg[s] <= func_next[s];
                v0_reg[s]   <= v0_next[s];
                v1_reg[s]   <= v1_next[s];
                sum_reg[s]  <= sum_next[s];
            end
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid set after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat missing from first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result dropped");

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vld_reg[STAGES-2]))
        else $error("result valid without a beat in the stage before");

endmodule

// ===== tb/xtea_block_cipher_test.sv =====
`timescale 1ns / 1ps

module xtea_block_cipher_test;
    import xtea_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int STALL_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam int RECONFIG_EVERY = 64;

    typedef struct {
        logic [31:0] high_half;
        logic [31:0] low_half;
    } cipher_block_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [ADDR_W-1:0] cfg_addr    = '0;
    logic [DATA_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata     = '0;   // block_high[31:0], block_low[63:32]
    logic              s_tuser     = 1'b0; // func
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [63:0]       m_tdata;            // result_high[31:0], result_low[63:32]

    // Local copy of the cipher settings
    logic [31:0]       key_words [4];
    logic [RC_W-1:0]   round_setting;

    cipher_block_t     pending_blocks [$];
    cipher_block_t     oldest_block;
    int                mismatches   = 0;
    int                stall_cycles = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    xtea_block_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [31:0] shift_mix(logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic cipher_block_t xtea_predict(logic func, logic [31:0] v0, logic [31:0] v1);
        logic [31:0]   sum;
        cipher_block_t res;
        if (func == FUNC_ENC) begin
            sum = '0;
            for (int i = 0; i < int'(round_setting); i++) begin
                v0 += shift_mix(v1) ^ (sum + key_words[sum[1:0]]);
                sum += DELTA;
                v1 += shift_mix(v0) ^ (sum + key_words[sum[12:11]]);
            end
        end else begin
            sum = DELTA * {25'd0, round_setting};
            for (int i = 0; i < int'(round_setting); i++) begin
                v1 -= shift_mix(v0) ^ (sum + key_words[sum[12:11]]);
                sum -= DELTA;
                v0 -= shift_mix(v1) ^ (sum + key_words[sum[1:0]]);
            end
        end
        res.high_half = v0;
        res.low_half  = v1;
        return res;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx <= REG_KEY3)
            key_words[idx[1:0]] = value;
        else if (idx == REG_ROUNDS)
            round_setting = value[RC_W-1:0];
    endtask

    // Leaves tvalid high so back-to-back beats need no gap.
    task automatic send_block(logic func, logic [31:0] hi, logic [31:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        pending_blocks.push_back(xtea_predict(func, hi, lo));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(negedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_block(FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_DEC, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_key_extremes();
        wait_idle();
        write_reg(REG_KEY0, 32'hFFFF_FFFF);
        write_reg(REG_KEY1, 32'hFFFF_FFFF);
        write_reg(REG_KEY2, 32'hFFFF_FFFF);
        write_reg(REG_KEY3, 32'hFFFF_FFFF);
        send_block(FUNC_ENC, 32'h0000_0000, 32'hFFFF_FFFF);
        send_block(FUNC_DEC, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_idle();
        write_reg(REG_KEY0, 32'hAAAA_AAAA);
        write_reg(REG_KEY1, 32'h5555_5555);
        write_reg(REG_KEY2, 32'h0000_0000);
        write_reg(REG_KEY3, 32'h8000_0001);
        send_block(FUNC_ENC, 32'h0000_0001, 32'h8000_0000);
        send_block(FUNC_DEC, 32'h8000_0000, 32'h0000_0001);
        send_block(FUNC_ENC, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(FUNC_DEC, 32'hFEDC_BA98, 32'h7654_3210);
    endtask

    task automatic test_round_extremes();
        logic [DATA_W-1:0] settings [4];
        settings = '{32'hFFFF_FF80, 32'd1, 32'd64, 32'hFFFF_FFFF}; // 0, 1, 64, 127 rounds
        foreach (settings[n]) begin
            wait_idle();
            write_reg(REG_ROUNDS, settings[n]);
            send_block(FUNC_ENC, $urandom, $urandom);
            send_block(FUNC_DEC, $urandom, $urandom);
        end
    endtask

    task automatic test_ignored_writes();
        wait_idle();
        write_reg(REG_ROUNDS, 32'd5);
        for (int a = int'(REG_ROUNDS) + 1; a < 2 ** ADDR_W; a++)
            write_reg(ADDR_W'(a), 32'hFFFF_FFFF);
        send_block(FUNC_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_block(FUNC_DEC, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_blocks(int count, int send_pct, int recv_pct);
        logic [RC_W-1:0] rc;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            if (n % RECONFIG_EVERY == 0) begin
                wait_idle();
                write_reg(REG_KEY0, random_word());
                write_reg(REG_KEY1, random_word());
                write_reg(REG_KEY2, random_word());
                write_reg(REG_KEY3, random_word());
                // mostly legal counts, now and then zero or past 64
                rc = ($urandom_range(9) == 0) ? RC_W'($urandom_range(127))
                                              : RC_W'($urandom_range(64, 1));
                write_reg(REG_ROUNDS, {$urandom_range(1) ? 25'($urandom) : 25'd0, rc});
                write_reg(ADDR_W'($urandom_range(2 ** ADDR_W - 1, int'(REG_ROUNDS) + 1)),
                          $urandom);
            end
            send_block(1'($urandom_range(1)), random_word(), random_word());
        end
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat with nothing pending: %h", m_tdata);
            end else begin
                oldest_block = pending_blocks.pop_front();
                if (m_tdata[31:0] !== oldest_block.high_half)
                    note_mismatch("result_high", oldest_block.high_half, m_tdata[31:0]);
                if (m_tdata[63:32] !== oldest_block.low_half)
                    note_mismatch("result_low", oldest_block.low_half, m_tdata[63:32]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("xtea_block_cipher_test NOT OK");
            $finish;
        end
    end

    initial begin
        key_words     = '{default: 32'h0};
        round_setting = RC_RESET;
        send_idle_pct = 16;
        recv_idle_pct = 59;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_key_extremes();
        test_round_extremes();
        test_ignored_writes();
        test_random_blocks(280, 16, 59);
        test_random_blocks(280, 59, 16);
        test_random_blocks(290, 0, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_blocks.size() == 0)
            $display("xtea_block_cipher_test OK");
        else
            $display("xtea_block_cipher_test NOT OK");
        $finish;
    end

endmodule
